@@ rtl/pfg_pkg.sv @@
package pfg_pkg;

	// Grid and queue sizing
	localparam int GRID_CELLS_DEF = 1024;
	localparam int QUEUE_DEPTH = 2;
	localparam int NUM_FIELDS = 6;
	localparam int NUM_CURRENTS = 3;

	// Field lanes that use the staggered (floor) weights: ex, by, bz
	localparam logic [NUM_FIELDS-1:0] STAGGERED_LANES = 6'b110001;

	// Configuration register indexes
	localparam logic [1:0] REG_INV_CELL_WIDTH = 2'd0;
	localparam logic [1:0] REG_CURRENT_FACTOR_X = 2'd1;
	localparam logic [1:0] REG_CURRENT_FACTOR_YZ = 2'd2;

	localparam logic [31:0] INV_CELL_WIDTH_RST = 32'h0001_0000;
	localparam logic signed [31:0] CURRENT_FACTOR_RST = 32'sh0001_0000;

	// Status codes
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_BAD_ADDR = 2'd1;
	localparam logic [1:0] STATUS_BIG_MOVE = 2'd2;

	localparam logic [16:0] Q16_ONE = 17'h1_0000;
	localparam logic signed [47:0] CUR_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] CUR_MIN = {1'b1, 47'b0};

	typedef enum logic [1:0] {
		MODE_FIELD_WR   = 2'd0,
		MODE_GATHER     = 2'd1,
		MODE_DEPOSIT    = 2'd2,
		MODE_CURRENT_RD = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [2:0]         component;
		logic [9:0]         cell_index;
		logic signed [31:0] value;
		logic signed [31:0] position;
		logic signed [31:0] displacement;
		logic signed [31:0] charge;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] e_x;
		logic signed [31:0] e_y;
		logic signed [31:0] e_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [11:0] near_cell;
		logic signed [47:0] current_value;
		logic [1:0]         status;
	} result_t;

	// Classified transaction as held in the queue
	typedef struct packed {
		mode_t              mode;
		logic [2:0]         component;
		logic [9:0]         cell_index;
		logic signed [31:0] value;
		logic               bad;
		logic signed [17:0] c1;
		logic signed [17:0] c2;
		logic [15:0]        g1;
		logic [15:0]        h1;
		logic signed [49:0] r;
		logic signed [31:0] charge;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} entry_t;

	// Clamp to the signed 48-bit current range
	function automatic logic signed [47:0] sat48(input logic signed [79:0] v);
		if (v[79:47] == {33{v[79]}})
			return v[47:0];
		return v[79] ? CUR_MIN : CUR_MAX;
	endfunction

endpackage

@@ rtl/pfg_ram.sv @@
module pfg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/pfg_front.sv @@
module pfg_front #(
	parameter int GRID_CELLS = pfg_pkg::GRID_CELLS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  pfg_pkg::item_t  item,
	input  logic [31:0]     inv_cell_width,
	input  logic            clearing,
	output logic            head_valid,
	output pfg_pkg::entry_t head,
	input  logic            pop
);

	localparam int PW = $clog2(pfg_pkg::QUEUE_DEPTH);

	pfg_pkg::entry_t fifo_q [pfg_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0] count_q;

	logic signed [32:0] t_sum, s_sum;
	logic signed [65:0] r_prod;
	logic signed [17:0] c1, c2;
	logic cell_oob, gather_bad, push;
	pfg_pkg::entry_t ent;

	// classify the incoming transaction
	always_comb begin
		t_sum = 33'(item.position) + 33'sd32768;
		s_sum = 33'(item.position) + 33'(item.displacement);
		r_prod = 66'(s_sum) * 66'($signed({1'b0, inv_cell_width}));
		c1 = 18'(t_sum >>> 16) + 18'sd1;
		c2 = 18'(item.position >>> 16) + 18'sd1;
		cell_oob = 32'(item.cell_index) >= GRID_CELLS;
		gather_bad = (32'(c1) < 0) || (32'(c1) > GRID_CELLS - 2) ||
			(32'(c2) < 0) || (32'(c2) > GRID_CELLS - 2);

		ent.mode = item.mode;
		ent.component = item.component;
		ent.cell_index = item.cell_index;
		ent.value = item.value;
		ent.c1 = c1;
		ent.c2 = c2;
		ent.g1 = t_sum[15:0];
		ent.h1 = item.position[15:0];
		ent.r = r_prod[65:16];
		ent.charge = item.charge;
		ent.vel_y = item.vel_y;
		ent.vel_z = item.vel_z;
		case (item.mode)
			pfg_pkg::MODE_FIELD_WR:
				ent.bad = (item.component > 3'(pfg_pkg::NUM_FIELDS - 1)) || cell_oob;
			pfg_pkg::MODE_CURRENT_RD:
				ent.bad = (item.component > 3'(pfg_pkg::NUM_CURRENTS - 1)) || cell_oob;
			pfg_pkg::MODE_GATHER:
				ent.bad = gather_bad;
			default:
				ent.bad = 1'b0;
		endcase
	end

	assign item_ready = (count_q != (PW+1)'(pfg_pkg::QUEUE_DEPTH)) && !clearing;
	assign push = item_valid && item_ready;
	assign head_valid = count_q != '0;
	assign head = fifo_q[rd_ptr_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= ent;
	end

endmodule

@@ rtl/pfg_back.sv @@
module pfg_back #(
	parameter int GRID_CELLS = pfg_pkg::GRID_CELLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  pfg_pkg::entry_t    head,
	output logic               pop,
	output logic               clearing,
	input  logic signed [31:0] current_factor_x,
	input  logic signed [31:0] current_factor_yz,
	output logic               result_valid,
	input  logic               result_ready,
	output pfg_pkg::result_t   result
);

	localparam int AW = $clog2(GRID_CELLS);
	localparam int GCW = AW + 1;
	localparam int NF = pfg_pkg::NUM_FIELDS;
	localparam int NC = pfg_pkg::NUM_CURRENTS;

	typedef enum logic [13:0] {
		ST_CLEAR = 14'b00000000000001,
		ST_IDLE  = 14'b00000000000010,
		ST_EXEC  = 14'b00000000000100,
		ST_RD    = 14'b00000000001000,
		ST_G1    = 14'b00000000010000,
		ST_G2    = 14'b00000000100000,
		ST_G3    = 14'b00000001000000,
		ST_D1    = 14'b00000010000000,
		ST_D2    = 14'b00000100000000,
		ST_D3    = 14'b00001000000000,
		ST_S1    = 14'b00010000000000,
		ST_S2    = 14'b00100000000000,
		ST_S3    = 14'b01000000000000,
		ST_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q, exec_next;
	pfg_pkg::entry_t it_q;
	pfg_pkg::result_t res_q, out_q;
	logic out_valid_q, out_load;
	logic [AW-1:0] clr_q;
	logic [GCW-1:0] gc_q;
	logic [16:0] g0_q;
	logic [15:0] g1_q;
	logic [1:0] exec_status;

	// deposit registers
	logic signed [63:0] fx_p_q, fyz_p_q;
	logic signed [47:0] fx_q, fyz_q, fy_q, fz_q;
	logic signed [64:0] pyl_q, pzl_q;
	logic signed [47:0] pyh_q, pzh_q;
	logic [1:0] dk_q, kmin_q, kmax_q, k_q;
	logic [15:0] low_q;
	logic signed [65:0] px_q;
	logic signed [66:0] py_q, pz_q;
	logic signed [47:0] jxh_q, jy_q, jz_q;

	// deposit decision
	logic signed [35:0] d_full;
	logic move_ok, dep_oob;
	logic [1:0] dk, kmin, kmax;
	logic [GCW:0] dep_top;

	// slot weights
	logic [16:0] new_w, gw_k;
	logic signed [17:0] w_k;
	logic [17:0] wy2;
	logic [AW-1:0] slot_addr;

	// memory ports
	logic [NF-1:0] f_we;
	logic f_re;
	logic signed [31:0] f_rdata [NF];
	logic signed [31:0] lane_sum_hi [NF];
	logic c_we, c_re;
	logic [AW-1:0] c_waddr, c_raddr;
	logic signed [47:0] c_wdata [NC];
	logic signed [47:0] c_rdata [NC];
	logic signed [47:0] j_sel [NC];

	assign clearing = state_q == ST_CLEAR;
	assign pop = (state_q == ST_IDLE) && head_valid;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;
	assign result = out_q;

	// deposit step and bounds
	always_comb begin
		d_full = 36'(it_q.r >>> 16) + 36'sd1 - 36'($signed({1'b0, gc_q}));
		move_ok = (d_full >= -36'sd1) && (d_full <= 36'sd1);
		dk = 2'(d_full + 36'sd1);
		kmin = (dk == 2'd0) ? 2'd0 : 2'd1;
		kmax = (dk == 2'd2) ? 2'd3 : 2'd2;
		dep_top = (GCW+1)'(gc_q) + (GCW+1)'(kmax) - (GCW+1)'(1);
		dep_oob = ((kmin == 2'd0) && (gc_q == '0)) || (32'(dep_top) >= GRID_CELLS);
	end

	// outcome of the first execute cycle
	always_comb begin
		exec_status = pfg_pkg::STATUS_OK;
		exec_next = ST_DONE;
		case (it_q.mode)
			pfg_pkg::MODE_FIELD_WR: begin
				if (it_q.bad)
					exec_status = pfg_pkg::STATUS_BAD_ADDR;
			end
			pfg_pkg::MODE_CURRENT_RD: begin
				if (it_q.bad)
					exec_status = pfg_pkg::STATUS_BAD_ADDR;
				else
					exec_next = ST_RD;
			end
			pfg_pkg::MODE_GATHER: begin
				if (it_q.bad)
					exec_status = pfg_pkg::STATUS_BAD_ADDR;
				else
					exec_next = ST_G1;
			end
			default: begin
				if (!move_ok)
					exec_status = pfg_pkg::STATUS_BIG_MOVE;
				else if (dep_oob)
					exec_status = pfg_pkg::STATUS_BAD_ADDR;
				else
					exec_next = ST_D1;
			end
		endcase
	end

	// new shape minus latched shape, their sum and the address for the current slot
	always_comb begin
		if (k_q == dk_q)
			new_w = pfg_pkg::Q16_ONE - 17'(low_q);
		else if (k_q == dk_q + 2'd1)
			new_w = 17'(low_q);
		else
			new_w = '0;
		if (k_q == 2'd1)
			gw_k = g0_q;
		else if (k_q == 2'd2)
			gw_k = 17'(g1_q);
		else
			gw_k = '0;
		w_k = $signed({1'b0, new_w}) - $signed({1'b0, gw_k});
		wy2 = 18'(new_w) + 18'(gw_k);
		slot_addr = AW'((GCW+1)'(gc_q) + (GCW+1)'(k_q) - (GCW+1)'(1));
	end

	// field store: one RAM per component
	assign f_re = ((state_q == ST_EXEC) && (it_q.mode == pfg_pkg::MODE_GATHER)) ||
		(state_q == ST_G1);

	for (genvar l = 0; l < NF; l++) begin : g_lane
		logic signed [17:0] lane_c;
		logic [AW-1:0] lane_addr;
		logic [15:0] w1;
		logic [16:0] w0;
		logic signed [31:0] a_q;
		logic signed [49:0] pa_q, pb_q;
		logic signed [50:0] lane_sum;

		assign lane_c = pfg_pkg::STAGGERED_LANES[l] ? it_q.c2 : it_q.c1;
		assign lane_addr = (state_q == ST_G1) ? AW'(lane_c) + 1'b1 : AW'(lane_c);
		assign w1 = pfg_pkg::STAGGERED_LANES[l] ? it_q.h1 : it_q.g1;
		assign w0 = pfg_pkg::Q16_ONE - 17'(w1);
		assign f_we[l] = (state_q == ST_EXEC) && (it_q.mode == pfg_pkg::MODE_FIELD_WR) &&
			!it_q.bad && (it_q.component == 3'(l));
		assign lane_sum = 51'(pa_q) + 51'(pb_q);
		assign lane_sum_hi[l] = lane_sum[47:16];

		pfg_ram #(.WIDTH(32), .DEPTH(GRID_CELLS)) u_field_ram (
			.clk   (clk),
			.we    (f_we[l]),
			.waddr (AW'(it_q.cell_index)),
			.wdata (it_q.value),
			.re    (f_re),
			.raddr (lane_addr),
			.rdata (f_rdata[l])
		);

		// weighted pair of neighbouring cells
		always_ff @(posedge clk) begin
			if (state_q == ST_G1)
				a_q <= f_rdata[l];
			if (state_q == ST_G2) begin
				pa_q <= 50'($signed({1'b0, w0})) * 50'(a_q);
				pb_q <= 50'($signed({1'b0, w1})) * 50'(f_rdata[l]);
			end
		end
	end

	// current store: one RAM per component, cleared after reset
	assign c_we = (state_q == ST_CLEAR) || (state_q == ST_S3);
	assign c_re = ((state_q == ST_EXEC) && (it_q.mode == pfg_pkg::MODE_CURRENT_RD) &&
		!it_q.bad) || (state_q == ST_S1);
	assign c_waddr = (state_q == ST_CLEAR) ? clr_q : slot_addr;
	assign c_raddr = (state_q == ST_EXEC) ? AW'(it_q.cell_index) : slot_addr;
	assign j_sel[0] = jxh_q;
	assign j_sel[1] = jy_q;
	assign j_sel[2] = jz_q;

	for (genvar j = 0; j < NC; j++) begin : g_cur
		assign c_wdata[j] = (state_q == ST_CLEAR) ? '0 :
			pfg_pkg::sat48(80'(c_rdata[j]) + 80'(j_sel[j]));

		pfg_ram #(.WIDTH(48), .DEPTH(GRID_CELLS)) u_cur_ram (
			.clk   (clk),
			.we    (c_we),
			.waddr (c_waddr),
			.wdata (c_wdata[j]),
			.re    (c_re),
			.raddr (c_raddr),
			.rdata (c_rdata[j])
		);
	end

	// sequencer and latched gather shape
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
			gc_q <= '0;
			g0_q <= '0;
			g1_q <= '0;
			k_q <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(GRID_CELLS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (head_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: state_q <= exec_next;
				ST_RD: state_q <= ST_DONE;
				ST_G1: state_q <= ST_G2;
				ST_G2: state_q <= ST_G3;
				ST_G3: begin
					gc_q <= GCW'(it_q.c1);
					g0_q <= pfg_pkg::Q16_ONE - 17'(it_q.g1);
					g1_q <= it_q.g1;
					state_q <= ST_DONE;
				end
				ST_D1: state_q <= ST_D2;
				ST_D2: state_q <= ST_D3;
				ST_D3: begin
					k_q <= kmin_q;
					state_q <= ST_S1;
				end
				ST_S1: state_q <= ST_S2;
				ST_S2: state_q <= ST_S3;
				ST_S3: begin
					k_q <= k_q + 2'd1;
					state_q <= (k_q == kmax_q) ? ST_DONE : ST_S1;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (pop) begin
			it_q <= head;
			res_q <= '0;
		end
		if (out_load)
			out_q <= res_q;
		case (state_q)
			ST_EXEC: begin
				res_q.status <= exec_status;
				fx_p_q <= 64'(current_factor_x) * 64'(it_q.charge);
				fyz_p_q <= 64'(current_factor_yz) * 64'(it_q.charge);
				dk_q <= dk;
				kmin_q <= kmin;
				kmax_q <= kmax;
				low_q <= it_q.r[15:0];
			end
			ST_RD: res_q.current_value <= c_rdata[it_q.component[1:0]];
			ST_G3: begin
				res_q.e_x <= lane_sum_hi[0];
				res_q.e_y <= lane_sum_hi[1];
				res_q.e_z <= lane_sum_hi[2];
				res_q.b_x <= lane_sum_hi[3];
				res_q.b_y <= lane_sum_hi[4];
				res_q.b_z <= lane_sum_hi[5];
				res_q.near_cell <= it_q.c1[11:0];
			end
			ST_D1: begin
				fx_q <= pfg_pkg::sat48(80'(fx_p_q >>> 8));
				fyz_q <= pfg_pkg::sat48(80'(fyz_p_q >>> 8));
			end
			ST_D2: begin
				// 48x32 products split into low and high partials
				pyl_q <= 65'($signed({1'b0, fyz_q[31:0]})) * 65'(it_q.vel_y);
				pyh_q <= 48'($signed(fyz_q[47:32])) * 48'(it_q.vel_y);
				pzl_q <= 65'($signed({1'b0, fyz_q[31:0]})) * 65'(it_q.vel_z);
				pzh_q <= 48'($signed(fyz_q[47:32])) * 48'(it_q.vel_z);
			end
			ST_D3: begin
				fy_q <= pfg_pkg::sat48(((80'(pyh_q) <<< 32) + 80'(pyl_q)) >>> 16);
				fz_q <= pfg_pkg::sat48(((80'(pzh_q) <<< 32) + 80'(pzl_q)) >>> 16);
				jxh_q <= '0;
			end
			ST_S1: begin
				px_q <= 66'(fx_q) * 66'(w_k);
				py_q <= 67'(fy_q) * 67'($signed({1'b0, wy2}));
				pz_q <= 67'(fz_q) * 67'($signed({1'b0, wy2}));
			end
			ST_S2: begin
				jxh_q <= pfg_pkg::sat48(80'(jxh_q) -
					80'(pfg_pkg::sat48(80'(px_q >>> 16))));
				jy_q <= pfg_pkg::sat48(80'(py_q >>> 17));
				jz_q <= pfg_pkg::sat48(80'(pz_q >>> 17));
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_cur_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		c_we |-> (state_q == ST_CLEAR || state_q == ST_S3))
		else $error("current store written outside clear or update");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (head_valid && state_q == ST_IDLE))
		else $error("queue popped while busy or empty");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S1) |-> (k_q >= kmin_q && k_q <= kmax_q))
		else $error("deposit slot outside its range");

	a_field_one_lane: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(f_we))
		else $error("more than one field array written");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !result_ready) |=> (state_q == ST_DONE))
		else $error("pending result overwritten");
`endif

endmodule

@@ rtl/pic_field_gather_current_deposit.sv @@
// 1D particle-in-cell kernel: field cell writes, top-hat field gather,
// charge-conserving current deposit and current cell reads over on-chip
// grid stores. A front stage classifies each transaction (address checks,
// gather cells and weights, new particle position) into a two-entry queue;
// a back sequencer executes one transaction at a time. A deposit touches
// two or three cells: the factor multiplication comes first, then a
// read-modify-write of the current RAMs for each cell in turn. After reset
// the current store is cleared one cell at a time, during which no
// transaction is accepted. Configuration writes are for times when the
// block is idle; the user must keep to this, since the block itself
// does not enforce it.
module pic_field_gather_current_deposit #(
	parameter int GRID_CELLS = pfg_pkg::GRID_CELLS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  pfg_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output pfg_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	logic [31:0] inv_cell_width_q;
	logic signed [31:0] current_factor_x_q, current_factor_yz_q;
	logic clearing, head_valid, pop;
	pfg_pkg::entry_t head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_cell_width_q <= pfg_pkg::INV_CELL_WIDTH_RST;
			current_factor_x_q <= pfg_pkg::CURRENT_FACTOR_RST;
			current_factor_yz_q <= pfg_pkg::CURRENT_FACTOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pfg_pkg::REG_INV_CELL_WIDTH: inv_cell_width_q <= cfg_data;
				pfg_pkg::REG_CURRENT_FACTOR_X: current_factor_x_q <= cfg_data;
				pfg_pkg::REG_CURRENT_FACTOR_YZ: current_factor_yz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pfg_front #(.GRID_CELLS(GRID_CELLS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.item           (item),
		.inv_cell_width (inv_cell_width_q),
		.clearing       (clearing),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop)
	);

	pfg_back #(.GRID_CELLS(GRID_CELLS)) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head_valid        (head_valid),
		.head              (head),
		.pop               (pop),
		.clearing          (clearing),
		.current_factor_x  (current_factor_x_q),
		.current_factor_yz (current_factor_yz_q),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.result            (result)
	);

endmodule
